// ===== hw/rtl/pee_pkg.sv =====
// Shared types and constants for the Paillier encrypt/decrypt unit.
package pee_pkg;

   localparam int N_BITS_DEF = 32;
   localparam int VAL_W      = 64;
   localparam int NUM_W      = 32;
   localparam int RAND_W     = 32;
   localparam int EU_T_W     = NUM_W + 2;
   localparam int NUM_CELLS  = 4;
   localparam int CELL_W     = $clog2(NUM_CELLS);
   localparam int STEPS      = 2 * VAL_W;
   localparam int STEP_W     = $clog2(STEPS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_N         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_N_SQUARED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR_G       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_LAMBDA    = 2'd3;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic {
      AU_MUL = 1'b0,
      AU_DIV = 1'b1
   } au_op_type;

   typedef struct packed {
      logic             start;
      au_op_type        op;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
      logic [VAL_W-1:0] m;
   } au_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [VAL_W-1:0] rem;
      logic [VAL_W-1:0] quo;
   } au_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ENC_POW_R,
      ST_ENC_MUL,
      ST_ENC_MUL_W,
      ST_DEC_POW_G,
      ST_DEC_LG1_W,
      ST_DEC_LG2,
      ST_DEC_LG2_W,
      ST_EU_CHK,
      ST_EU_DIV_W,
      ST_EU_MUL,
      ST_EU_UPD,
      ST_EU_DONE,
      ST_DEC_POW_C,
      ST_DEC_LC_W,
      ST_DEC_MUL,
      ST_DEC_MUL_W,
      ST_POW_INIT,
      ST_POW_BASE_W,
      ST_POW_LOOP,
      ST_POW_ACC_W,
      ST_POW_SQ,
      ST_POW_SQ_W,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/pee_ifs.sv =====
// Request and response channel interfaces of the Paillier unit.
interface pee_req_if;
   import pee_pkg::*;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [VAL_W-1:0]  data_value;
   logic [RAND_W-1:0] random_factor;
   modport source (output valid, opcode, data_value, random_factor, input ready);
   modport sink (input valid, opcode, data_value, random_factor, output ready);
endinterface

interface pee_rsp_if;
   import pee_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] result_value;
   logic             error_flag;
   modport source (output valid, result_value, error_flag, input ready);
   modport sink (input valid, result_value, error_flag, output ready);
endinterface

// ===== hw/rtl/pee_cell.sv =====
// One ring cell: modular add of accumulator and addend, or doubling of the accumulator, registered.
module pee_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic                   dbl,
   input  logic [pee_pkg::VAL_W-1:0] addend,
   input  logic [pee_pkg::VAL_W-1:0] modulus,
   input  logic [pee_pkg::VAL_W-1:0] acc_in,
   output logic [pee_pkg::VAL_W-1:0] acc_ff,
   output logic                   sub
);
   import pee_pkg::*;

   logic [VAL_W:0]   sum;
   logic [VAL_W-1:0] acc_in_nxt;

   always_comb begin
      sum        = {1'b0, acc_in} + {1'b0, (dbl ? acc_in : addend)};
      sub        = (sum >= {1'b0, modulus});
      acc_in_nxt = sub ? VAL_W'(sum - {1'b0, modulus}) : sum[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in_nxt;
      end
   end
endmodule

// ===== hw/rtl/pee_arith.sv =====
// Modular multiply / divide unit built on a ring of add-reduce cells.
module pee_arith (
   input  logic                clock,
   input  logic                reset,
   input  pee_pkg::au_cmd_type cmd,
   output pee_pkg::au_sts_type sts
);
   import pee_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   au_op_type         op_ff, op_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [VAL_W-1:0]  b_ff, b_in;
   logic [VAL_W-1:0]  m_ff, m_in;
   logic [VAL_W-1:0]  q_ff, q_in;
   logic              hold_ff, hold_in;

   logic [VAL_W-1:0]     cell_acc [NUM_CELLS];
   logic [VAL_W-1:0]     cell_in  [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_sub;
   logic                 dbl;
   logic [VAL_W-1:0]     addend;
   logic                 sub_now;

   always_comb begin
      dbl = ~step_ff[0];
      if (dbl) begin
         addend = '0;
      end else if (op_ff == AU_MUL) begin
         addend = b_ff[VAL_W-1] ? a_ff : '0;
      end else begin
         addend = VAL_W'(b_ff[VAL_W-1]);
      end
      sub_now = cell_sub[step_ff[CELL_W-1:0]];
   end

   // item value walks the ring, one half step per cell
   genvar k;
   generate
      for (k = 0; k < NUM_CELLS; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign cell_in[k] = (step_ff == '0) ? '0 : cell_acc[NUM_CELLS-1];
         end else begin : g_link
            assign cell_in[k] = cell_acc[k-1];
         end
         pee_cell u_cell (
            .clock   (clock),
            .en      (busy_ff),
            .dbl     (dbl),
            .addend  (addend),
            .modulus (m_ff),
            .acc_in  (cell_in[k]),
            .acc_ff  (cell_acc[k]),
            .sub     (cell_sub[k])
         );
      end
   endgenerate

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      q_in    = q_ff;
      hold_in = hold_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         op_in   = cmd.op;
         a_in    = cmd.a;
         b_in    = cmd.b;
         m_in    = cmd.m;
         q_in    = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff[0]) begin
            b_in = {b_ff[VAL_W-2:0], 1'b0};
            q_in = {q_ff[VAL_W-2:0], hold_ff | sub_now};
         end else begin
            hold_in = sub_now;
         end
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      q_ff    <= q_in;
      hold_ff <= hold_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.rem  = cell_acc[NUM_CELLS-1];
   assign sts.quo  = q_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done longer than one cycle");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.start && step_ff == STEP_W'(STEPS - 1)) |=> (done_ff && !busy_ff))
      else $error("last step did not finish");
   a_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (busy_ff && step_ff == '0))
      else $error("start not taken");
endmodule

// ===== hw/rtl/paillier_encrypt_decrypt_unit.sv =====
// Paillier encrypt/decrypt unit: sequencer over a shared modular arithmetic ring.
// Each modular multiply or divide runs 128 half steps around a 4-cell ring.
// Encrypt: two modular powers (g^m and r^n mod n^2) and one modular multiply.
// Decrypt: two 32-bit-exponent powers plus extended Euclid.
// One item in flight; next item accepted once the result is in the output register.
// Synchronous active-high reset; n and n^2 reset to 1, g and lambda to 0.
module paillier_encrypt_decrypt_unit #(
   parameter int N_BITS = pee_pkg::N_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pee_req_if.sink                          req_chan,
   pee_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [pee_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pee_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pee_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [N_BITS-1:0] n_ff;
   logic [VAL_W-1:0]  n2_ff;
   logic [VAL_W-1:0]  g_ff;
   logic [NUM_W-1:0]  lam_ff;

   op_type            op_ff, op_in;
   logic [VAL_W-1:0]  data_ff, data_in;
   logic [RAND_W-1:0] rand_ff, rand_in;

   logic [VAL_W-1:0] pw_base_ff, pw_base_in;
   logic [VAL_W-1:0] pw_acc_ff, pw_acc_in;
   logic [VAL_W-1:0] pw_exp_ff, pw_exp_in;
   logic [VAL_W-1:0] pw_mod_ff, pw_mod_in;
   logic [VAL_W-1:0] gm_ff, gm_in;
   logic [VAL_W-1:0] tmp_ff, tmp_in;

   logic [NUM_W-1:0]         eu_r0_ff, eu_r0_in;
   logic [NUM_W-1:0]         eu_r1_ff, eu_r1_in;
   logic [NUM_W-1:0]         eu_q_ff, eu_q_in;
   logic [NUM_W-1:0]         eu_rem_ff, eu_rem_in;
   logic signed [EU_T_W-1:0] eu_t0_ff, eu_t0_in;
   logic signed [EU_T_W-1:0] eu_t1_ff, eu_t1_in;
   logic signed [EU_T_W-1:0] eu_prod_ff, eu_prod_in;
   logic [NUM_W-1:0]         mu_ff, mu_in;

   logic [VAL_W-1:0] res_ff, res_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_res_ff, rsp_res_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [NUM_W-1:0]         n_eff;
   logic [VAL_W-1:0]         n64;
   logic signed [EU_T_W-1:0] n_s;
   au_cmd_type               cmd;
   au_sts_type               sts;

   assign n_eff = NUM_W'(n_ff);
   assign n64   = VAL_W'(n_eff);
   assign n_s   = $signed(EU_T_W'(n_eff));

   pee_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      data_in      = data_ff;
      rand_in      = rand_ff;
      pw_base_in   = pw_base_ff;
      pw_acc_in    = pw_acc_ff;
      pw_exp_in    = pw_exp_ff;
      pw_mod_in    = pw_mod_ff;
      gm_in        = gm_ff;
      tmp_in       = tmp_ff;
      eu_r0_in     = eu_r0_ff;
      eu_r1_in     = eu_r1_ff;
      eu_q_in      = eu_q_ff;
      eu_rem_in    = eu_rem_ff;
      eu_t0_in     = eu_t0_ff;
      eu_t1_in     = eu_t1_ff;
      eu_prod_in   = eu_prod_ff;
      mu_in        = mu_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_err_in   = rsp_err_ff;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.opcode);
               data_in  = req_chan.data_value;
               rand_in  = req_chan.random_factor;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in = '0;
            err_in = 1'b0;
            if (op_ff == OP_ENCRYPT) begin
               pw_base_in = g_ff;
               pw_exp_in  = data_ff;
               pw_mod_in  = n2_ff;
               ret_in     = ST_ENC_POW_R;
               state_in   = ST_POW_INIT;
            end else if (n_eff == '0) begin
               err_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               pw_base_in = g_ff;
               pw_exp_in  = VAL_W'(lam_ff);
               pw_mod_in  = n2_ff;
               ret_in     = ST_DEC_POW_G;
               state_in   = ST_POW_INIT;
            end
         end
         ST_ENC_POW_R: begin
            gm_in      = pw_acc_ff;
            pw_base_in = VAL_W'(rand_ff);
            pw_exp_in  = n64;
            pw_mod_in  = n2_ff;
            ret_in     = ST_ENC_MUL;
            state_in   = ST_POW_INIT;
         end
         ST_ENC_MUL: begin
            if (n2_ff == '0) begin
               res_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_MUL;
               cmd.a     = gm_ff;
               cmd.b     = pw_acc_ff;
               cmd.m     = n2_ff;
               state_in  = ST_ENC_MUL_W;
            end
         end
         ST_ENC_MUL_W: begin
            if (sts.done) begin
               res_in   = sts.rem;
               state_in = ST_FINISH;
            end
         end
         ST_DEC_POW_G: begin
            if (pw_acc_ff == '0) begin
               err_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_DIV;
               cmd.b     = pw_acc_ff - 1'b1;
               cmd.m     = n64;
               state_in  = ST_DEC_LG1_W;
            end
         end
         ST_DEC_LG1_W: begin
            if (sts.done) begin
               tmp_in   = sts.quo;
               state_in = ST_DEC_LG2;
            end
         end
         ST_DEC_LG2: begin
            cmd.start = 1'b1;
            cmd.op    = AU_DIV;
            cmd.b     = tmp_ff;
            cmd.m     = n64;
            state_in  = ST_DEC_LG2_W;
         end
         ST_DEC_LG2_W: begin
            if (sts.done) begin
               eu_r0_in = n_eff;
               eu_r1_in = sts.rem[NUM_W-1:0];
               eu_t0_in = '0;
               eu_t1_in = EU_T_W'(1);
               state_in = ST_EU_CHK;
            end
         end
         ST_EU_CHK: begin
            if (eu_r1_ff == '0) begin
               state_in = ST_EU_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_DIV;
               cmd.b     = VAL_W'(eu_r0_ff);
               cmd.m     = VAL_W'(eu_r1_ff);
               state_in  = ST_EU_DIV_W;
            end
         end
         ST_EU_DIV_W: begin
            if (sts.done) begin
               eu_q_in   = sts.quo[NUM_W-1:0];
               eu_rem_in = sts.rem[NUM_W-1:0];
               state_in  = ST_EU_MUL;
            end
         end
         ST_EU_MUL: begin
            eu_prod_in = EU_T_W'($signed(EU_T_W'(eu_q_ff)) * eu_t1_ff);
            state_in   = ST_EU_UPD;
         end
         ST_EU_UPD: begin
            eu_r0_in = eu_r1_ff;
            eu_r1_in = eu_rem_ff;
            eu_t0_in = eu_t1_ff;
            eu_t1_in = eu_t0_ff - eu_prod_ff;
            state_in = ST_EU_CHK;
         end
         ST_EU_DONE: begin
            if (eu_r0_ff != NUM_W'(1)) begin
               err_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               if (eu_t0_ff < 0) begin
                  mu_in = NUM_W'(eu_t0_ff + n_s);
               end else if (eu_t0_ff >= n_s) begin
                  mu_in = NUM_W'(eu_t0_ff - n_s);
               end else begin
                  mu_in = NUM_W'(eu_t0_ff);
               end
               pw_base_in = data_ff;
               pw_exp_in  = VAL_W'(lam_ff);
               pw_mod_in  = n2_ff;
               ret_in     = ST_DEC_POW_C;
               state_in   = ST_POW_INIT;
            end
         end
         ST_DEC_POW_C: begin
            if (pw_acc_ff == '0) begin
               err_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_DIV;
               cmd.b     = pw_acc_ff - 1'b1;
               cmd.m     = n64;
               state_in  = ST_DEC_LC_W;
            end
         end
         ST_DEC_LC_W: begin
            if (sts.done) begin
               tmp_in   = sts.quo;
               state_in = ST_DEC_MUL;
            end
         end
         ST_DEC_MUL: begin
            cmd.start = 1'b1;
            cmd.op    = AU_MUL;
            cmd.a     = VAL_W'(mu_ff);
            cmd.b     = tmp_ff;
            cmd.m     = n64;
            state_in  = ST_DEC_MUL_W;
         end
         ST_DEC_MUL_W: begin
            if (sts.done) begin
               res_in   = sts.rem;
               state_in = ST_FINISH;
            end
         end
         ST_POW_INIT: begin
            if (pw_mod_ff == '0) begin
               pw_acc_in = '0;
               state_in  = ret_ff;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_DIV;
               cmd.b     = pw_base_ff;
               cmd.m     = pw_mod_ff;
               state_in  = ST_POW_BASE_W;
            end
         end
         ST_POW_BASE_W: begin
            if (sts.done) begin
               pw_base_in = sts.rem;
               pw_acc_in  = (pw_mod_ff == VAL_W'(1)) ? '0 : VAL_W'(1);
               state_in   = ST_POW_LOOP;
            end
         end
         ST_POW_LOOP: begin
            if (pw_exp_ff == '0) begin
               state_in = ret_ff;
            end else if (pw_exp_ff[0]) begin
               cmd.start = 1'b1;
               cmd.op    = AU_MUL;
               cmd.a     = pw_acc_ff;
               cmd.b     = pw_base_ff;
               cmd.m     = pw_mod_ff;
               state_in  = ST_POW_ACC_W;
            end else begin
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_ACC_W: begin
            if (sts.done) begin
               pw_acc_in = sts.rem;
               state_in  = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            pw_exp_in = {1'b0, pw_exp_ff[VAL_W-1:1]};
            if (pw_exp_ff[VAL_W-1:1] == '0) begin
               state_in = ST_POW_LOOP;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = AU_MUL;
               cmd.a     = pw_base_ff;
               cmd.b     = pw_base_ff;
               cmd.m     = pw_mod_ff;
               state_in  = ST_POW_SQ_W;
            end
         end
         ST_POW_SQ_W: begin
            if (sts.done) begin
               pw_base_in = sts.rem;
               state_in   = ST_POW_LOOP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = err_ff ? '0 : res_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= N_BITS'(1);
         n2_ff        <= VAL_W'(1);
         g_ff         <= '0;
         lam_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODULUS_N:         n_ff   <= csr_wdata[N_BITS-1:0];
               CSR_MODULUS_N_SQUARED: n2_ff  <= csr_wdata[VAL_W-1:0];
               CSR_GENERATOR_G:       g_ff   <= csr_wdata[VAL_W-1:0];
               CSR_PRIVATE_LAMBDA:    lam_ff <= csr_wdata[NUM_W-1:0];
               default: ;
            endcase
         end
      end
      op_ff      <= op_in;
      data_ff    <= data_in;
      rand_ff    <= rand_in;
      pw_base_ff <= pw_base_in;
      pw_acc_ff  <= pw_acc_in;
      pw_exp_ff  <= pw_exp_in;
      pw_mod_ff  <= pw_mod_in;
      gm_ff      <= gm_in;
      tmp_ff     <= tmp_in;
      eu_r0_ff   <= eu_r0_in;
      eu_r1_ff   <= eu_r1_in;
      eu_q_ff    <= eu_q_in;
      eu_rem_ff  <= eu_rem_in;
      eu_t0_ff   <= eu_t0_in;
      eu_t1_ff   <= eu_t1_in;
      eu_prod_ff <= eu_prod_in;
      mu_ff      <= mu_in;
      res_ff     <= res_in;
      err_ff     <= err_in;
      rsp_res_ff <= rsp_res_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_res_ff;
   assign rsp_chan.error_flag   = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_res_ff == '0))
      else $error("error item with nonzero result");
   a_enc_no_err: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && err_ff) |-> (op_ff == OP_DECRYPT))
      else $error("encrypt flagged an error");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !sts.busy)
      else $error("arith unit started while busy");
endmodule

// ===== bench/pee_result_checker.sv =====
// Checker for the Paillier unit: tracks the registers, predicts each result and compares.
module pee_result_checker #(
   parameter int N_BITS = pee_pkg::N_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   pee_req_if                             req,
   pee_rsp_if                             rsp,
   input  logic                           csr_wr_en,
   input  logic [pee_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pee_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import pee_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic             err;
   } paillier_result_type;

   logic [63:0] key_n, key_n2, key_g, key_lambda;
   paillier_result_type expected_results[$];

   function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      if (m == 0) return 64'd0;
      prod = {64'd0, a % m} * {64'd0, b % m};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      if (m == 0) return 64'd0;
      acc = 64'd1 % m;
      base = base % m;
      for (int i = 0; i < 64; i++) begin
         if (e[i]) acc = mod_mul(acc, base, m);
         base = mod_mul(base, base, m);
      end
      return acc;
   endfunction

   function automatic bit mod_inverse(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
      longint r0, r1, t0, t1, q, tmp;
      r0 = longint'(m);
      r1 = longint'(a);
      t0 = 0;
      t1 = 1;
      inv = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = r0 - q * r1;
         r0 = r1;
         r1 = tmp;
         tmp = t0 - q * t1;
         t0 = t1;
         t1 = tmp;
      end
      if (r0 != 1) return 1'b0;
      if (t0 < 0) t0 += longint'(m);
      inv = 64'(t0) % m;
      return 1'b1;
   endfunction

   function automatic paillier_result_type paillier_predict(op_type op, logic [63:0] data,
                                                            logic [31:0] r);
      paillier_result_type res;
      logic [63:0] n, xg, xc, lg, lc, mu;
      n = key_n & ((64'd1 << N_BITS) - 1);
      res.value = 0;
      res.err = 1'b1;
      if (op == OP_ENCRYPT) begin
         res.value = mod_mul(mod_pow(key_g, data, key_n2), mod_pow({32'd0, r}, n, key_n2),
                             key_n2);
         res.err = 1'b0;
         return res;
      end
      if (n == 0) return res;
      xg = mod_pow(key_g, key_lambda, key_n2);
      if (xg == 0) return res;
      lg = ((xg - 1) / n) % n;
      if (!mod_inverse(lg, n, mu)) return res;
      xc = mod_pow(data, key_lambda, key_n2);
      if (xc == 0) return res;
      lc = (xc - 1) / n;
      res.value = mod_mul(lc, mu, n);
      res.err = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      paillier_result_type want;
      if (reset) begin
         key_n <= 64'd1;
         key_n2 <= 64'd1;
         key_g <= 64'd0;
         key_lambda <= 64'd0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODULUS_N:         key_n <= {32'd0, csr_wdata[31:0]};
               CSR_MODULUS_N_SQUARED: key_n2 <= csr_wdata;
               CSR_GENERATOR_G:       key_g <= csr_wdata;
               CSR_PRIVATE_LAMBDA:    key_lambda <= {32'd0, csr_wdata[31:0]};
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_results.push_back(paillier_predict(op_type'(req.opcode), req.data_value,
                                                        req.random_factor));
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp.result_value, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.result_value !== want.value)
                  report_mismatch("result_value", rsp.result_value, want.value);
               if (rsp.error_flag !== want.err)
                  report_mismatch("error_flag", {63'd0, rsp.error_flag}, {63'd0, want.err});
            end
         end
      end
   end

endmodule

// ===== bench/tb_paillier_encrypt_decrypt_unit.sv =====
// Top of the Paillier unit testbench: clock, reset, stimulus, register phases and verdict.
module tb_paillier_encrypt_decrypt_unit;
   import pee_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    num_enc, num_dec, num_phases;

   pee_req_if req_if ();
   pee_rsp_if rsp_if ();

   paillier_encrypt_decrypt_unit u_dut (
      .clock(clock), .reset(reset), .req_chan(req_if), .rsp_chan(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pee_result_checker u_checker (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

   // response side: random stall before each item, sometimes none
   initial begin
      int k;
      rsp_if.ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (k > 0) begin
            rsp_if.ready <= 0;
            repeat (k) @(posedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
      end
   end

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   task automatic send_item(op_type op, logic [63:0] data, logic [31:0] r, bit no_gaps);
      int k;
      k = no_gaps ? 0 : $urandom_range(0, 13);
      if (k > 0) begin
         req_if.valid <= 0;
         repeat (k) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.opcode <= op;
      req_if.data_value <= data;
      req_if.random_factor <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (op == OP_ENCRYPT) num_enc++;
      else num_dec++;
   endtask

   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_key(logic [63:0] n, logic [63:0] n2, logic [63:0] g, logic [63:0] lam);
      csr_wr_en <= 1;
      csr_index <= CSR_MODULUS_N;         csr_wdata <= n;   @(posedge clock);
      csr_index <= CSR_MODULUS_N_SQUARED; csr_wdata <= n2;  @(posedge clock);
      csr_index <= CSR_GENERATOR_G;       csr_wdata <= g;   @(posedge clock);
      csr_index <= CSR_PRIVATE_LAMBDA;    csr_wdata <= lam; @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [63:0] n, logic [63:0] n2, int count, bit no_gaps);
      logic [63:0] data;
      logic [31:0] r;
      op_type      op;
      send_item(OP_DECRYPT, 64'd0, 32'd0, no_gaps);
      send_item(OP_ENCRYPT, 64'd1, 32'hFFFF_FFFF, no_gaps);
      repeat (count) begin
         op = op_type'($urandom_range(0, 1));
         if ($urandom_range(0, 9) < 7) begin
            data = (op == OP_ENCRYPT) ? 64'($urandom_range(0, 4095)) : {$urandom, $urandom};
            if (op == OP_DECRYPT && n2 != 0) data = data % n2;
            r = (n != 0) ? 32'($urandom % n[31:0]) : $urandom;
         end else begin
            data = {$urandom, $urandom};
            r = $urandom;
         end
         send_item(op, data, r, no_gaps);
      end
      drain();
      num_phases++;
   endtask

   initial begin
      logic [63:0] n, lam, rn, rn2;
      num_enc = 0;
      num_dec = 0;
      num_phases = 0;
      reset = 1;
      csr_wr_en = 0;
      csr_index = CSR_MODULUS_N;
      csr_wdata = 0;
      req_if.valid = 0;
      req_if.opcode = OP_ENCRYPT;
      req_if.data_value = 0;
      req_if.random_factor = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset key, with full-width extremes
      send_item(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0);
      run_phase(64'd1, 64'd1, 8, 0);

      // small textbook key p=11 q=13
      load_key(143, 143 * 143, 144, 60);
      run_phase(143, 143 * 143, 14, 1);

      // large key p=65521 q=65519
      n = 64'd65521 * 64'd65519;
      lam = (64'd65520 * 64'd65518) / gcd64(64'd65520, 64'd65518);
      load_key(n, n * n, n + 1, lam);
      send_item(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
      run_phase(n, n * n, 14, 0);

      // random generator with the large key: inverse may not exist
      load_key(n, n * n, {$urandom, $urandom}, lam);
      run_phase(n, n * n, 10, 0);

      // zero moduli
      load_key(0, 0, {$urandom, $urandom}, $urandom);
      run_phase(0, 0, 8, 1);

      // all ones
      load_key(64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF);
      run_phase(64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0);

      // unrelated random values
      rn = {32'd0, $urandom};
      rn2 = {$urandom, $urandom};
      load_key(rn, rn2, {$urandom, $urandom}, $urandom);
      run_phase(rn, rn2, 10, 0);

      $display("Covered %0d key settings: %0d encrypt and %0d decrypt items.",
               num_phases, num_enc, num_dec);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
